### rtl/shl_pkg.sv
package shl_pkg;

    // character codes used by the lexer
    localparam logic [7:0] ESC_RESET   = 8'hB6;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_BTICK    = 8'h60;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;

    localparam logic [15:0] LINE_RESET = 16'd1;

    // result kinds
    localparam logic KIND_TEXT   = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // quoting states; each escape variant follows its plain state
    typedef enum logic [4:0] {
        ST_TEXT, ST_TEXT_E, ST_COMM, ST_COMM_E, ST_VSTR, ST_VSTR_E,
        ST_DSTR, ST_DSTR_E, ST_SSTR, ST_SSTR_E, ST_EBEG, ST_E1, ST_E1_E,
        ST_E2, ST_E2_E, ST_E3, ST_FSTR, ST_FSTR_E, ST_BSTR, ST_BSTR_E
    } lex_state_t;

    // one queued action: up to two results for one input transfer
    typedef struct packed {
        logic        first_kind;
        logic [7:0]  first_byte;
        logic        second_valid;
        logic [7:0]  second_byte;
        logic [15:0] line;
    } lex_action_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // states that hold back an escape byte
    function automatic logic holds_escape(input lex_state_t s);
        logic r;
        begin
            case (s)
                ST_TEXT_E, ST_VSTR_E, ST_DSTR_E, ST_SSTR_E,
                ST_E1_E, ST_E2_E, ST_FSTR_E, ST_BSTR_E: r = 1'b1;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

    // plain state for an escape variant
    function automatic lex_state_t unescaped(input lex_state_t s);
        lex_state_t r;
        begin
            case (s)
                ST_TEXT_E: r = ST_TEXT;
                ST_VSTR_E: r = ST_VSTR;
                ST_DSTR_E: r = ST_DSTR;
                ST_SSTR_E: r = ST_SSTR;
                ST_E1_E:   r = ST_E1;
                ST_E2_E:   r = ST_E2;
                ST_FSTR_E: r = ST_FSTR;
                ST_BSTR_E: r = ST_BSTR;
                default:   r = ST_TEXT;
            endcase
            return r;
        end
    endfunction

    function automatic lex_state_t text_next(input logic [7:0] c, input logic [7:0] e);
        lex_state_t r;
        begin
            if (c == CH_HASH) begin
                r = ST_COMM;
            end else if (c == e) begin
                r = ST_TEXT_E;
            end else begin
                case (c)
                    CH_LBRACE: r = ST_VSTR;
                    CH_DQUOTE: r = ST_DSTR;
                    CH_SQUOTE: r = ST_SSTR;
                    CH_BTICK:  r = ST_EBEG;
                    CH_SLASH:  r = ST_FSTR;
                    CH_BSLASH: r = ST_BSTR;
                    default:   r = ST_TEXT;
                endcase
            end
            return r;
        end
    endfunction

    function automatic lex_state_t quoted(input logic [7:0] c, input logic [7:0] e,
                                          input logic [7:0] close,
                                          input lex_state_t base,
                                          input lex_state_t base_e);
        lex_state_t r;
        begin
            if (c == close) begin
                r = ST_TEXT;
            end else if (c == e) begin
                r = base_e;
            end else begin
                r = base;
            end
            return r;
        end
    endfunction

endpackage

### rtl/shl_front.sv
module shl_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_finish,
    input  shl_pkg::q_status_t    q_status,
    output logic                  push,
    output shl_pkg::lex_action_t  action
);

    shl_pkg::lex_state_t state_reg, state_next;
    logic [15:0]         line_reg, line_next;
    logic                content_reg, content_next;
    logic [7:0]          esc_reg;

    logic accept;
    logic is_nl;
    logic esc_held;
    logic end_cmd;
    logic emit_c;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_nl    = in_finish || (in_byte == shl_pkg::CH_CR) || (in_byte == shl_pkg::CH_LF);
    assign esc_held = shl_pkg::holds_escape(state_reg);

    // escape code register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= shl_pkg::ESC_RESET;
        end else if (cfg_wr_en) begin
            esc_reg <= cfg_wr_data;
        end
    end

    // next quoting state
    always_comb begin
        if (is_nl) begin
            state_next = esc_held ? shl_pkg::unescaped(state_reg) : shl_pkg::ST_TEXT;
        end else begin
            case (state_reg)
                shl_pkg::ST_COMM:
                    state_next = (in_byte == esc_reg) ? shl_pkg::ST_COMM_E : shl_pkg::ST_COMM;
                shl_pkg::ST_COMM_E:
                    state_next = shl_pkg::ST_COMM;
                shl_pkg::ST_TEXT_E, shl_pkg::ST_DSTR_E, shl_pkg::ST_E1_E, shl_pkg::ST_E2_E:
                    state_next = shl_pkg::unescaped(state_reg);
                shl_pkg::ST_SSTR, shl_pkg::ST_SSTR_E:
                    state_next = shl_pkg::quoted(in_byte, esc_reg, shl_pkg::CH_SQUOTE,
                                                 shl_pkg::ST_SSTR, shl_pkg::ST_SSTR_E);
                shl_pkg::ST_FSTR, shl_pkg::ST_FSTR_E:
                    state_next = shl_pkg::quoted(in_byte, esc_reg, shl_pkg::CH_SLASH,
                                                 shl_pkg::ST_FSTR, shl_pkg::ST_FSTR_E);
                shl_pkg::ST_BSTR, shl_pkg::ST_BSTR_E:
                    state_next = shl_pkg::quoted(in_byte, esc_reg, shl_pkg::CH_BSLASH,
                                                 shl_pkg::ST_BSTR, shl_pkg::ST_BSTR_E);
                shl_pkg::ST_VSTR, shl_pkg::ST_VSTR_E:
                    state_next = shl_pkg::quoted(in_byte, esc_reg, shl_pkg::CH_RBRACE,
                                                 shl_pkg::ST_VSTR, shl_pkg::ST_VSTR_E);
                shl_pkg::ST_DSTR:
                    state_next = shl_pkg::quoted(in_byte, esc_reg, shl_pkg::CH_DQUOTE,
                                                 shl_pkg::ST_DSTR, shl_pkg::ST_DSTR_E);
                shl_pkg::ST_EBEG:
                    state_next = (in_byte == shl_pkg::CH_BTICK) ? shl_pkg::ST_E2 :
                                 shl_pkg::quoted(in_byte, esc_reg, shl_pkg::CH_BTICK,
                                                 shl_pkg::ST_E1, shl_pkg::ST_E1_E);
                shl_pkg::ST_E1:
                    state_next = shl_pkg::quoted(in_byte, esc_reg, shl_pkg::CH_BTICK,
                                                 shl_pkg::ST_E1, shl_pkg::ST_E1_E);
                shl_pkg::ST_E2:
                    state_next = (in_byte == shl_pkg::CH_BTICK) ? shl_pkg::ST_E3 :
                                 (in_byte == esc_reg) ? shl_pkg::ST_E2_E : shl_pkg::ST_E2;
                shl_pkg::ST_E3:
                    state_next = (in_byte == shl_pkg::CH_BTICK) ? shl_pkg::ST_TEXT :
                                 shl_pkg::text_next(in_byte, esc_reg);
                default:
                    state_next = shl_pkg::text_next(in_byte, esc_reg);
            endcase
        end
    end

    // decide what this transfer produces
    always_comb begin
        end_cmd = in_finish || !(esc_held || (state_reg == shl_pkg::ST_COMM_E));
        emit_c  = (state_reg != shl_pkg::ST_COMM) && (state_reg != shl_pkg::ST_COMM_E) &&
                  (state_next != shl_pkg::ST_COMM) && !shl_pkg::holds_escape(state_next);
        action.line = line_reg;
        if (is_nl) begin
            push                = accept && end_cmd && content_reg;
            action.first_kind   = shl_pkg::KIND_MARKER;
            action.first_byte   = 8'h00;
            action.second_valid = 1'b0;
            action.second_byte  = 8'h00;
            content_next        = content_reg && !end_cmd;
            line_next           = line_reg + 16'd1;
        end else begin
            push                = accept && (esc_held || emit_c);
            action.first_kind   = shl_pkg::KIND_TEXT;
            action.first_byte   = esc_held ? esc_reg : in_byte;
            action.second_valid = esc_held && emit_c;
            action.second_byte  = in_byte;
            content_next        = content_reg || esc_held || emit_c;
            line_next           = line_reg;
        end
    end

    // lexer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= shl_pkg::ST_TEXT;
            line_reg    <= shl_pkg::LINE_RESET;
            content_reg <= 1'b0;
        end else if (accept) begin
            state_reg   <= state_next;
            line_reg    <= line_next;
            content_reg <= content_next;
        end
    end

endmodule

### rtl/shl_queue.sv
module shl_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  shl_pkg::lex_action_t  push_data,
    input  logic                  pop,
    output shl_pkg::lex_action_t  head,
    output shl_pkg::q_status_t    status
);

    shl_pkg::lex_action_t               slot_reg [shl_pkg::QDEPTH];
    logic [shl_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [shl_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [shl_pkg::QCNT_W-1:0]         count_reg;

    assign status.full  = (count_reg == shl_pkg::QCNT_W'(shl_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + shl_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + shl_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + shl_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - shl_pkg::QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("queue read while empty");

endmodule

### rtl/shl_back.sv
module shl_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  shl_pkg::lex_action_t  head,
    input  shl_pkg::q_status_t    q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_kind,
    output logic [7:0]            out_byte,
    output logic [15:0]           out_line,
    output logic                  out_last
);

    logic        valid_reg;
    logic        second_reg;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic [15:0] line_reg;
    logic        last_reg;
    logic        load;

    // output slot is free when empty or being drained this cycle
    assign load = (!valid_reg || out_ready) && !q_status.empty;
    assign pop  = load && (second_reg || !head.second_valid);

    // result register and second-result phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg  <= 1'b1;
                second_reg <= !second_reg && head.second_valid;
            end else if (out_ready) begin
                valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            line_reg <= head.line;
            if (second_reg) begin
                kind_reg <= shl_pkg::KIND_TEXT;
                byte_reg <= head.second_byte;
                last_reg <= 1'b1;
            end else begin
                kind_reg <= head.first_kind;
                byte_reg <= head.first_byte;
                last_reg <= !head.second_valid;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_line  = line_reg;
    assign out_last  = last_reg;

    a_phase_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> !q_status.empty)
        else $error("second result pending with no queued entry");

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (kind_reg == shl_pkg::KIND_MARKER)) |-> last_reg)
        else $error("end-of-command marker not flagged last");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !second_reg && head.second_valid) |=> (second_reg && !last_reg))
        else $error("first of two results flagged last");

endmodule

### rtl/shell_line_lexer.sv
// Shell line lexer: first-phase lexing of a command shell source stream.
// Input channel (s_axis): one raw source byte per transfer; tuser set means
// finish, which acts as a newline and then closes any open command.
// Output channel (m_axis): command text bytes and end-of-command markers,
// each tagged with the line count as it stood before the causing byte;
// tlast flags the last result produced by one input transfer. An input byte
// yields zero, one or two results.
// Configuration: cfg_wr_en/cfg_wr_data write the escape byte at any idle time.
// Throughput: one input byte per cycle while the queue is not full; the output
// side delivers one result per cycle while m_axis_tready is high, and a byte
// that releases a held escape yields two results. The front decodes the quoting
// state combinationally and writes a four-entry queue; the back drains it into
// a registered output, so each result passes the queue and the output register.
// Reset (aresetn low, synchronous): text state, line count 1, empty command,
// escape byte 0xB6, queue and output emptied.
// Receiver stall: results wait in the output register and queue; s_axis_tready
// drops only when the queue is full.
module shell_line_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] finish
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] line_number
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // last
);

    shl_pkg::lex_action_t action;
    shl_pkg::lex_action_t head;
    shl_pkg::q_status_t   q_status;
    logic                 push;
    logic                 pop;
    logic [7:0]           out_byte;
    logic [15:0]          out_line;

    // state tracking and classification
    shl_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_finish   (s_axis_tuser),
        .q_status    (q_status),
        .push        (push),
        .action      (action)
    );

    // decoupling queue
    shl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (action),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // result sequencing
    shl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_byte  (out_byte),
        .out_line  (out_line),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_line, out_byte};

endmodule

### tb/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYC   = 4;
    localparam int HOLD_CYC     = 300;
    localparam int PHASE_ITEMS  = 170;
    localparam int N_PHASES     = 8;
    localparam int N_DIRECTED   = 25;

    // one result as seen on the output channel
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] line;
        logic        last;
    } lex_result_t;

    // directed stimulus row; typed rows carry their expected results
    typedef struct {
        logic [7:0]  b;
        logic        fin;
        logic        typed;
        int          n;
        logic        k0;
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [15:0] ln;
    } dir_row_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [7:0]  cfg_wr_data   = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_axis_tuser  = 1'b0;    // [0] finish
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [7:0] out_byte, [23:8] line_number
    logic        m_axis_tuser;            // [0] kind
    logic        m_axis_tlast;

    // lexer shadow state
    shl_pkg::lex_state_t lex_st    = shl_pkg::ST_TEXT;
    logic [15:0]         line_cnt  = shl_pkg::LINE_RESET;
    logic                cmd_open  = 1'b0;
    logic [7:0]          esc_byte  = shl_pkg::ESC_RESET;

    lex_result_t pending_q[$];
    int          errs      = 0;
    int          cycles    = 0;
    int          sent      = 0;
    bit          quiet     = 1'b0;
    bit          hold_req  = 1'b0;

    dir_row_t dir_tab [N_DIRECTED] = '{
        '{8'h61, 1'b0, 1'b1, 1, shl_pkg::KIND_TEXT, 8'h61, 8'h00, 16'd1},
        '{shl_pkg::CH_LF, 1'b0, 1'b1, 1, shl_pkg::KIND_MARKER, 8'h00, 8'h00, 16'd1},
        '{shl_pkg::CH_LF, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{8'h00, 1'b0, 1'b1, 1, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd3},
        '{8'hFF, 1'b0, 1'b1, 1, shl_pkg::KIND_TEXT, 8'hFF, 8'h00, 16'd3},
        '{shl_pkg::ESC_RESET, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_LF, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::ESC_RESET, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{8'h78, 1'b0, 1'b1, 2, shl_pkg::KIND_TEXT, shl_pkg::ESC_RESET, 8'h78, 16'd4},
        '{shl_pkg::CH_HASH, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::ESC_RESET, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{8'h7A, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::ESC_RESET, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_CR, 1'b0, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_LBRACE, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_RBRACE, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_DQUOTE, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::ESC_RESET, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_DQUOTE, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_DQUOTE, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_BTICK, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_BTICK, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{shl_pkg::CH_BTICK, 1'b0, 1'b0, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0},
        '{8'h00, 1'b1, 1'b1, 1, shl_pkg::KIND_MARKER, 8'h00, 8'h00, 16'd5},
        '{8'hAB, 1'b1, 1'b1, 0, shl_pkg::KIND_TEXT, 8'h00, 8'h00, 16'd0}
    };

    shell_line_lexer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // states that keep an escape byte back
    function automatic logic is_holding(input shl_pkg::lex_state_t s);
        return s == shl_pkg::ST_TEXT_E || s == shl_pkg::ST_VSTR_E ||
               s == shl_pkg::ST_DSTR_E || s == shl_pkg::ST_SSTR_E ||
               s == shl_pkg::ST_E1_E || s == shl_pkg::ST_E2_E ||
               s == shl_pkg::ST_FSTR_E || s == shl_pkg::ST_BSTR_E;
    endfunction

    // state after a byte seen in plain text; hash beats the escape byte
    function automatic shl_pkg::lex_state_t text_follow(input logic [7:0] c,
                                                        input logic [7:0] e);
        if (c == shl_pkg::CH_HASH) return shl_pkg::ST_COMM;
        if (c == e) return shl_pkg::ST_TEXT_E;
        case (c)
            shl_pkg::CH_LBRACE: return shl_pkg::ST_VSTR;
            shl_pkg::CH_DQUOTE: return shl_pkg::ST_DSTR;
            shl_pkg::CH_SQUOTE: return shl_pkg::ST_SSTR;
            shl_pkg::CH_BTICK:  return shl_pkg::ST_EBEG;
            shl_pkg::CH_SLASH:  return shl_pkg::ST_FSTR;
            shl_pkg::CH_BSLASH: return shl_pkg::ST_BSTR;
            default:            return shl_pkg::ST_TEXT;
        endcase
    endfunction

    // quoted string: the closing byte wins over the escape byte
    function automatic shl_pkg::lex_state_t quote_follow(input logic [7:0] c,
                                                         input logic [7:0] e,
                                                         input logic [7:0] close,
                                                         input shl_pkg::lex_state_t base);
        if (c == close) return shl_pkg::ST_TEXT;
        if (c == e) return shl_pkg::lex_state_t'(5'(base) + 5'd1);
        return base;
    endfunction

    // append one expected result at the tail of the scoreboard
    task automatic queue_expected(input lex_result_t r);
        pending_q.insert(pending_q.size(), r);
    endtask

    // advance the shadow lexer by one input transfer and list its results
    task automatic lex_advance(input logic [7:0] c, input logic fin, output int n,
                               output lex_result_t r0, output lex_result_t r1);
        shl_pkg::lex_state_t s;
        shl_pkg::lex_state_t nx;
        logic                end_cmd;
        lex_result_t         res [2];
        begin
            n = 0;
            res[0] = '0;
            res[1] = '0;
            s = lex_st;
            if (fin || c == shl_pkg::CH_CR || c == shl_pkg::CH_LF) begin
                end_cmd = fin;
                if (is_holding(s)) begin
                    nx = shl_pkg::lex_state_t'(5'(s) - 5'd1);
                end else if (s == shl_pkg::ST_COMM_E) begin
                    nx = shl_pkg::ST_TEXT;
                end else begin
                    nx = shl_pkg::ST_TEXT;
                    end_cmd = 1'b1;
                end
                if (end_cmd && cmd_open) begin
                    res[n] = '{shl_pkg::KIND_MARKER, 8'h00, line_cnt, 1'b0};
                    n++;
                    cmd_open = 1'b0;
                end
                line_cnt = line_cnt + 16'd1;
            end else begin
                // a held escape goes out ahead of the new byte
                if (is_holding(s)) begin
                    res[n] = '{shl_pkg::KIND_TEXT, esc_byte, line_cnt, 1'b0};
                    n++;
                    cmd_open = 1'b1;
                end
                case (s)
                    shl_pkg::ST_COMM:
                        nx = (c == esc_byte) ? shl_pkg::ST_COMM_E : shl_pkg::ST_COMM;
                    shl_pkg::ST_COMM_E:
                        nx = shl_pkg::ST_COMM;
                    shl_pkg::ST_TEXT_E, shl_pkg::ST_DSTR_E, shl_pkg::ST_E1_E, shl_pkg::ST_E2_E:
                        nx = shl_pkg::lex_state_t'(5'(s) - 5'd1);
                    shl_pkg::ST_SSTR, shl_pkg::ST_SSTR_E:
                        nx = quote_follow(c, esc_byte, shl_pkg::CH_SQUOTE, shl_pkg::ST_SSTR);
                    shl_pkg::ST_FSTR, shl_pkg::ST_FSTR_E:
                        nx = quote_follow(c, esc_byte, shl_pkg::CH_SLASH, shl_pkg::ST_FSTR);
                    shl_pkg::ST_BSTR, shl_pkg::ST_BSTR_E:
                        nx = quote_follow(c, esc_byte, shl_pkg::CH_BSLASH, shl_pkg::ST_BSTR);
                    shl_pkg::ST_VSTR, shl_pkg::ST_VSTR_E:
                        nx = quote_follow(c, esc_byte, shl_pkg::CH_RBRACE, shl_pkg::ST_VSTR);
                    shl_pkg::ST_DSTR:
                        nx = quote_follow(c, esc_byte, shl_pkg::CH_DQUOTE, shl_pkg::ST_DSTR);
                    shl_pkg::ST_EBEG: begin
                        nx = (c == shl_pkg::CH_BTICK) ? shl_pkg::ST_E2 :
                             quote_follow(c, esc_byte, shl_pkg::CH_BTICK, shl_pkg::ST_E1);
                    end
                    shl_pkg::ST_E1:
                        nx = quote_follow(c, esc_byte, shl_pkg::CH_BTICK, shl_pkg::ST_E1);
                    shl_pkg::ST_E2: begin
                        nx = (c == shl_pkg::CH_BTICK) ? shl_pkg::ST_E3 :
                             (c == esc_byte) ? shl_pkg::ST_E2_E : shl_pkg::ST_E2;
                    end
                    shl_pkg::ST_E3: begin
                        nx = (c == shl_pkg::CH_BTICK) ? shl_pkg::ST_TEXT :
                             text_follow(c, esc_byte);
                    end
                    default:  nx = text_follow(c, esc_byte);
                endcase
                // comments swallow bytes, an escape byte waits one step
                if (s != shl_pkg::ST_COMM && s != shl_pkg::ST_COMM_E &&
                    nx != shl_pkg::ST_COMM && !is_holding(nx)) begin
                    res[n] = '{shl_pkg::KIND_TEXT, c, line_cnt, 1'b0};
                    n++;
                    cmd_open = 1'b1;
                end
            end
            lex_st = nx;
            if (n > 0) res[n - 1].last = 1'b1;
            r0 = res[0];
            r1 = res[1];
        end
    endtask

    // present one byte and wait for the transfer
    task automatic offer_byte(input logic [7:0] b, input logic fin);
        int gap;
        begin
            if (!quiet && $urandom_range(99) < 3) begin
                s_axis_tvalid <= 1'b0;
                gap = $urandom_range(4, 1);
                repeat (gap) @(posedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= b;
            s_axis_tuser  <= fin;
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            sent++;
        end
    endtask

    // transfer a byte and queue what the shadow lexer says it yields
    task automatic feed(input logic [7:0] b, input logic fin);
        int          n;
        lex_result_t r0;
        lex_result_t r1;
        begin
            offer_byte(b, fin);
            lex_advance(b, fin, n, r0, r1);
            if (n > 0) queue_expected(r0);
            if (n > 1) queue_expected(r1);
        end
    endtask

    // stop sending and let the block drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_escape(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        esc_byte = v;
    endtask

    // one random source fragment, mostly well-formed quoting
    task automatic lex_chunk();
        int         pick;
        int         len;
        logic [7:0] op;
        logic [7:0] cl;
        begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                len = $urandom_range(6, 1);
                repeat (len) feed(8'($urandom_range(126, 33)), 1'b0);
            end else if (pick < 45) begin
                case ($urandom_range(5))
                    0: begin op = shl_pkg::CH_LBRACE; cl = shl_pkg::CH_RBRACE; end
                    1: begin op = shl_pkg::CH_DQUOTE; cl = shl_pkg::CH_DQUOTE; end
                    2: begin op = shl_pkg::CH_SQUOTE; cl = shl_pkg::CH_SQUOTE; end
                    3: begin op = shl_pkg::CH_SLASH;  cl = shl_pkg::CH_SLASH;  end
                    4: begin op = shl_pkg::CH_BSLASH; cl = shl_pkg::CH_BSLASH; end
                    default: begin op = shl_pkg::CH_BTICK; cl = shl_pkg::CH_BTICK; end
                endcase
                feed(op, 1'b0);
                len = $urandom_range(5);
                repeat (len) begin
                    if ($urandom_range(4) == 0) feed(esc_byte, 1'b0);
                    else feed(8'($urandom_range(255)), 1'b0);
                end
                feed(cl, 1'b0);
            end else if (pick < 55) begin
                // triple backtick block
                repeat (3) feed(shl_pkg::CH_BTICK, 1'b0);
                len = $urandom_range(4);
                repeat (len) begin
                    if ($urandom_range(3) == 0) feed(esc_byte, 1'b0);
                    else feed(8'($urandom_range(255)), 1'b0);
                end
                repeat ($urandom_range(3, 1)) feed(shl_pkg::CH_BTICK, 1'b0);
            end else if (pick < 67) begin
                // escape, then a line join or an ordinary byte
                feed(esc_byte, 1'b0);
                if ($urandom_range(2) == 0) begin
                    feed($urandom_range(1) ? shl_pkg::CH_LF : shl_pkg::CH_CR, 1'b0);
                end else begin
                    feed(8'($urandom_range(255)), 1'b0);
                end
            end else if (pick < 77) begin
                feed(shl_pkg::CH_HASH, 1'b0);
                len = $urandom_range(5);
                repeat (len) begin
                    if ($urandom_range(3) == 0) feed(esc_byte, 1'b0);
                    else feed(8'($urandom_range(255)), 1'b0);
                end
                feed($urandom_range(1) ? shl_pkg::CH_LF : shl_pkg::CH_CR, 1'b0);
            end else if (pick < 90) begin
                feed($urandom_range(1) ? shl_pkg::CH_LF : shl_pkg::CH_CR, 1'b0);
            end else if (pick < 93) begin
                feed(8'($urandom_range(255)), 1'b1);
            end else begin
                feed(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin : result_check
        lex_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                errs++;
                $display("%0t: unexpected result kind %b byte %h line %h last %b", $time,
                         m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast);
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    errs++;
                    $display("%0t: kind mismatch expected %b actual %b", $time,
                             want.kind, m_axis_tuser);
                end
                if (m_axis_tdata[7:0] !== want.data) begin
                    errs++;
                    $display("%0t: out_byte mismatch expected %h actual %h", $time,
                             want.data, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[23:8] !== want.line) begin
                    errs++;
                    $display("%0t: line_number mismatch expected %h actual %h", $time,
                             want.line, m_axis_tdata[23:8]);
                end
                if (m_axis_tlast !== want.last) begin
                    errs++;
                    $display("%0t: last mismatch expected %b actual %b", $time,
                             want.last, m_axis_tlast);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int          n;
        lex_result_t r0;
        lex_result_t r1;
        lex_result_t typed_res;
        logic [7:0]  esc_val;
        logic [7:0]  esc_set [N_PHASES - 1];
        begin
            esc_set = '{8'h00, 8'hFF, shl_pkg::CH_HASH, shl_pkg::CH_BTICK, shl_pkg::CH_LF,
                        shl_pkg::CH_RBRACE, shl_pkg::ESC_RESET};
            repeat (8) @(posedge aclk);
            aresetn <= 1'b1;

            // directed rows at the reset escape byte
            for (int i = 0; i < N_DIRECTED; i++) begin
                offer_byte(dir_tab[i].b, dir_tab[i].fin);
                lex_advance(dir_tab[i].b, dir_tab[i].fin, n, r0, r1);
                if (dir_tab[i].typed) begin
                    for (int k = 0; k < dir_tab[i].n; k++) begin
                        typed_res.kind = (k == 0) ? dir_tab[i].k0 : shl_pkg::KIND_TEXT;
                        typed_res.data = (k == 0) ? dir_tab[i].d0 : dir_tab[i].d1;
                        typed_res.line = dir_tab[i].ln;
                        typed_res.last = (k == dir_tab[i].n - 1);
                        queue_expected(typed_res);
                    end
                end else begin
                    if (n > 0) queue_expected(r0);
                    if (n > 1) queue_expected(r1);
                end
            end

            // random phases, each under its own escape byte
            for (int p = 0; p < N_PHASES; p++) begin
                settle();
                esc_val = (p < N_PHASES - 1) ? esc_set[p] : 8'($urandom_range(255));
                write_escape(esc_val);
                if (p == 2) begin
                    quiet = 1'b1;
                    hold_req = 1'b1;
                end
                sent = 0;
                while (sent < PHASE_ITEMS) lex_chunk();
                quiet = 1'b0;
            end

            // close the stream with an open command and finish
            settle();
            write_escape(shl_pkg::ESC_RESET);
            feed(8'h62, 1'b0);
            feed(8'h00, 1'b1);

            settle();
            repeat (8) @(posedge aclk);
            if (errs == 0 && pending_q.size() == 0) begin
                $display("PASS");
            end else begin
                $display("FAIL");
            end
            $finish;
        end
    end

endmodule
